@@ rtl/irst_pkg.sv @@
// Package for the interval set table: status codes, kinds and shared types.
// No dependencies.
package irst_pkg;

  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD_RNG = 2'd2;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic        shift;    // open a slot at split_key
    logic [31:0] split_key;
    logic        mark;     // mark every interval in [mark_lo, mark_hi]
    logic [31:0] mark_lo;
    logic [31:0] mark_hi;
  } cell_cmd_t;

  // per-cell status returned to the controller
  typedef struct packed {
    logic valid;
    logic ge;     // bound >= probe key
    logic eq;     // bound == probe key
    logic marked;
  } cell_stat_t;

endpackage

@@ rtl/irst_if.sv @@
// Valid/ready channel interfaces for the interval set table.
// No dependencies; the interfaces do not use irst_pkg.
interface irst_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] first_addr;
  logic [31:0] last_addr;
  modport source (output valid, kind, first_addr, last_addr, input ready);
  modport sink   (input valid, kind, first_addr, last_addr, output ready);
endinterface

interface irst_out_if;
  logic       valid;
  logic       ready;
  logic       member;
  logic [1:0] status;
  modport source (output valid, member, status, input ready);
  modport sink   (input valid, member, status, output ready);
endinterface

@@ rtl/irst_cell.sv @@
// One table cell: a bound, its mark and a valid bit; takes its left
// neighbor's contents on a shift. Depends on irst_pkg.
module irst_cell
  import irst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        is_first,
  input  cell_cmd_t   cmd,
  input  logic [31:0] probe,
  input  logic        left_valid,
  input  logic [31:0] left_key,
  input  logic        left_marked,
  input  logic        left_ge,     // left neighbor bound >= split key
  output logic [31:0] key_o,
  output cell_stat_t  stat
);

  logic        valid_r, valid_nxt;
  logic        marked_r, marked_nxt;
  logic [31:0] key_r, key_nxt;
  logic        here_ge;

  assign here_ge = key_r >= cmd.split_key;

  // shift right of the split point, insert split key at the first slot
  always_comb begin
    valid_nxt  = valid_r;
    marked_nxt = marked_r;
    key_nxt    = key_r;
    if (cmd.shift) begin
      if (valid_r && here_ge) begin
        if (!is_first && left_valid && left_ge) begin
          key_nxt    = left_key;
          marked_nxt = left_marked;
        end else begin
          key_nxt    = cmd.split_key;
          marked_nxt = marked_r;
        end
      end else if (!valid_r && left_valid) begin
        valid_nxt  = 1'b1;
        key_nxt    = left_key;
        marked_nxt = left_marked;
      end
    end else if (cmd.mark && valid_r) begin
      // interval lower edge lies at or below hi, upper bound at or above lo
      if (key_r >= cmd.mark_lo && (is_first || !left_valid || left_key < cmd.mark_hi))
        marked_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= is_first;
      marked_r <= 1'b0;
      key_r    <= U32_MAX;
    end else begin
      valid_r  <= valid_nxt;
      marked_r <= marked_nxt;
      key_r    <= key_nxt;
    end
  end

  assign key_o       = key_r;
  assign stat.valid  = valid_r;
  assign stat.ge     = valid_r && (key_r >= probe);
  assign stat.eq     = valid_r && (key_r == probe);
  assign stat.marked = marked_r;

endmodule

@@ rtl/irst_ctrl.sv @@
// Sequencer: probes the cell row, issues split and mark commands, builds
// the result word. Depends on irst_pkg.
module irst_ctrl
  import irst_pkg::*;
#(
  parameter int N = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  irst_in_if.sink      in_ch,
  irst_out_if.source   out_ch,
  input  cell_stat_t   stat [N],
  output logic [31:0]  probe,
  output cell_cmd_t    cmd
);

  localparam int CW = $clog2(N + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHKLO = 3'd1;
  localparam logic [2:0] S_CHKHI = 3'd2;
  localparam logic [2:0] S_SPLLO = 3'd3;
  localparam logic [2:0] S_SPLHI = 3'd4;
  localparam logic [2:0] S_MARK  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic          kind_r;
  logic [31:0]   first_r, last_r;
  logic          need_lo_r, need_lo_nxt;
  logic          member_r, member_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_member_r;
  logic [1:0]    out_status_r;
  logic          out_load;
  logic          hit_any, hit_eq, hit_mark;
  logic          need_hi;
  logic [CW:0]   total;

  // first cell with bound >= probe: its eq and mark
  always_comb begin
    hit_any  = 1'b0;
    hit_eq   = 1'b0;
    hit_mark = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (stat[i].ge && !hit_any) begin
        hit_any  = 1'b1;
        hit_eq   = stat[i].eq;
        hit_mark = stat[i].marked;
      end
    end
  end

  assign need_hi = !hit_eq;
  assign total   = {1'b0, count_r} + (CW+1)'(need_lo_r) + (CW+1)'(need_hi);

  // lookups probe the address itself, inserts probe first-1 then last
  always_comb begin
    unique case (state_r)
      S_CHKLO:          probe = (kind_r == KIND_LOOKUP) ? first_r : first_r - 32'd1;
      S_SPLLO:          probe = first_r - 32'd1;
      S_CHKHI, S_SPLHI: probe = last_r;
      default:          probe = first_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    need_lo_nxt   = need_lo_r;
    member_nxt    = member_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.split_key = probe;
    cmd.mark_lo   = first_r;
    cmd.mark_hi   = last_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_CHKLO;
      S_CHKLO: begin
        member_nxt = 1'b0;
        status_nxt = ST_OK;
        if (kind_r == KIND_LOOKUP) begin
          member_nxt = hit_mark;
          state_nxt  = S_OUT;
        end else if (first_r > last_r) begin
          status_nxt = ST_BAD_RNG;
          state_nxt  = S_OUT;
        end else begin
          need_lo_nxt = (first_r != 32'd0) && !hit_eq;
          state_nxt   = S_CHKHI;
        end
      end
      S_CHKHI: begin
        if (total > (CW+1)'(N)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_OUT;
        end else state_nxt = S_SPLLO;
      end
      S_SPLLO: begin
        if (need_lo_r) begin
          cmd.shift = 1'b1;
          count_nxt = count_r + CW'(1);
        end
        state_nxt = S_SPLHI;
      end
      S_SPLHI: begin
        if (!hit_eq) begin
          cmd.shift = 1'b1;
          count_nxt = count_r + CW'(1);
        end
        state_nxt = S_MARK;
      end
      S_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (!out_valid_r || out_ch.ready) begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // capture the word on accept; load the result register when it frees up
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_r  <= in_ch.kind;
      first_r <= in_ch.first_addr;
      last_r  <= in_ch.last_addr;
    end
    if (out_load) begin
      out_member_r <= member_r;
      out_status_r <= status_r;
    end
    need_lo_r <= need_lo_nxt;
    member_r  <= member_nxt;
    status_r  <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.member = out_member_r;
  assign out_ch.status = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(N)) else $error("entry count above table size");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r) else $error("result dropped");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("second word taken");

endmodule

@@ rtl/ip_range_set_table_top.sv @@
// Top level of the interval set table: controller plus a row of cells.
// Depends on irst_pkg, irst_if, irst_cell and irst_ctrl.
// One word is handled at a time. A lookup goes from accept through the
// probe state to the result state; an insert goes through probe low, probe
// high, two split steps that shift the cell row when a bound is new, one
// broadcast-compare mark pass and the result. Bad inserts end after the low
// probe and full inserts after the high probe. A new word may be accepted
// while the previous result still waits. The table holds MAX_INTERVALS
// intervals, one per cell; no clearing pass is needed after reset.
module ip_range_set_table_top
  import irst_pkg::*;
#(
  parameter int MAX_INTERVALS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  irst_in_if.sink     in_ch,
  irst_out_if.source  out_ch
);

  cell_stat_t  stat [MAX_INTERVALS];
  logic [31:0] keys [MAX_INTERVALS];
  logic [31:0] probe;
  cell_cmd_t   cmd;

  irst_ctrl #(.N(MAX_INTERVALS)) u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .stat, .probe, .cmd
  );

  // chain of cells, each fed from its left neighbor
  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    logic        lv, lm, lg;
    logic [31:0] lk;
    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign lm = 1'b0;
      assign lg = 1'b0;
      assign lk = '0;
    end else begin : g_body
      assign lv = stat[i-1].valid;
      assign lm = stat[i-1].marked;
      assign lk = keys[i-1];
      assign lg = keys[i-1] >= cmd.split_key;
    end
    irst_cell u_cell (
      .clk, .rst_n, .is_first(i == 0), .cmd, .probe,
      .left_valid(lv), .left_key(lk), .left_marked(lm), .left_ge(lg),
      .key_o(keys[i]), .stat(stat[i])
    );
  end

endmodule
